// File: rtl/lvtcp_pkg.sv
package lvtcp_pkg;

	localparam int CW   = 32;
	localparam int TW   = 16;
	localparam int FRAC = 14;
	localparam int VW   = 40;
	localparam int ZW   = CW + 1 + TW + 1 - FRAC;
	localparam int PMW1 = CW + 1 + TW;
	localparam int PMW2 = ZW + TW;
	localparam int PW   = VW + 2;
	localparam int CDW  = VW + 1;
	localparam int CRW  = CDW + 2;
	localparam int SCW  = 15;
	localparam int NW   = PW + 1 + SCW;
	localparam int PDW  = VW + 1;
	localparam int QW   = 15;
	localparam int OW   = 16;
	localparam int CLAT = CDW;
	localparam int PLAT = QW + 1;
	localparam int IN_W  = 6 * CW;
	localparam int OUT_W = 4 * OW;

	localparam int NEAR_Z        = 26;
	localparam int Z_MIN         = 1;
	localparam int SCREEN_WIDTH  = 1920;
	localparam int SCREEN_HEIGHT = 1080;

	localparam logic signed [VW-1:0]  NEAR_V = VW'(NEAR_Z);
	localparam logic signed [VW-1:0]  ZMIN_V = VW'(Z_MIN);
	localparam logic signed [SCW-1:0] SW_V   = SCW'(SCREEN_WIDTH);
	localparam logic signed [SCW-1:0] SH_V   = SCW'(SCREEN_HEIGHT);
	localparam logic signed [OW-1:0]  SAT_MAX = 16'sh7fff;
	localparam logic signed [OW-1:0]  SAT_MIN = 16'sh8000;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam int AW = 5;
	localparam int DW = 32;
	localparam logic [2:0] REG_CAMERA_X     = 3'd0;
	localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
	localparam logic [2:0] REG_CAMERA_Z     = 3'd2;
	localparam logic [2:0] REG_YAW_COSINE   = 3'd3;
	localparam logic [2:0] REG_YAW_SINE     = 3'd4;
	localparam logic [2:0] REG_PITCH_COSINE = 3'd5;
	localparam logic [2:0] REG_PITCH_SINE   = 3'd6;

	typedef struct packed {
		logic signed [CW-1:0] camera_x;
		logic signed [CW-1:0] camera_y;
		logic signed [CW-1:0] camera_z;
		logic signed [TW-1:0] yaw_cosine;
		logic signed [TW-1:0] yaw_sine;
		logic signed [TW-1:0] pitch_cosine;
		logic signed [TW-1:0] pitch_sine;
	} cfg_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
	} vpoint_t;

	typedef struct packed {
		logic    visible;
		logic    a_near;
		logic    b_near;
		vpoint_t a;
		vpoint_t b;
	} item_t;

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [VW-1:0] z;
	} cpoint_t;

	typedef struct packed {
		logic    visible;
		logic    clip_a;
		logic    clip_b;
		logic    neg_x;
		logic    neg_y;
		vpoint_t a;
		vpoint_t b;
	} clip_meta_t;

endpackage

// File: rtl/lvtcp_front.sv
module lvtcp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lvtcp_pkg::cfg_t               cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lvtcp_pkg::IN_W-1:0]    s_tdata,
	output logic                          push,
	output lvtcp_pkg::item_t              push_item,
	input  logic                          full
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [lvtcp_pkg::CW:0]     vx_s1 [2];
	logic signed [lvtcp_pkg::CW:0]     vy_s1 [2];
	logic signed [lvtcp_pkg::CW:0]     vz_s1 [2];
	logic signed [lvtcp_pkg::PMW1-1:0] xc_s2 [2];
	logic signed [lvtcp_pkg::PMW1-1:0] zs_s2 [2];
	logic signed [lvtcp_pkg::PMW1-1:0] zc_s2 [2];
	logic signed [lvtcp_pkg::PMW1-1:0] xs_s2 [2];
	logic signed [lvtcp_pkg::CW:0]     vy_s2 [2];
	logic signed [lvtcp_pkg::VW-1:0]   x_s3  [2];
	logic signed [lvtcp_pkg::ZW-1:0]   z1_s3 [2];
	logic signed [lvtcp_pkg::CW:0]     vy_s3 [2];
	logic signed [lvtcp_pkg::PMW2-1:0] ycp_s4 [2];
	logic signed [lvtcp_pkg::PMW2-1:0] zsp_s4 [2];
	logic signed [lvtcp_pkg::PMW2-1:0] zcp_s4 [2];
	logic signed [lvtcp_pkg::PMW2-1:0] ysp_s4 [2];
	logic signed [lvtcp_pkg::VW-1:0]   x_s4  [2];
	lvtcp_pkg::vpoint_t                pt [2];
	logic                              near [2];

	assign en       = !v_s4 || !full;
	assign s_tready = en;
	assign push     = v_s4 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	for (genvar p = 0; p < 2; p++) begin : g_pt
		logic signed [lvtcp_pkg::CW-1:0]   ix, iy, iz;
		logic signed [lvtcp_pkg::PMW1:0]   sx, sz;
		logic signed [lvtcp_pkg::PMW2:0]   sy, sz2;

		assign ix = s_tdata[(3*p)*lvtcp_pkg::CW +: lvtcp_pkg::CW];
		assign iy = s_tdata[(3*p+1)*lvtcp_pkg::CW +: lvtcp_pkg::CW];
		assign iz = s_tdata[(3*p+2)*lvtcp_pkg::CW +: lvtcp_pkg::CW];

		assign sx  = (lvtcp_pkg::PMW1+1)'(xc_s2[p]) + (lvtcp_pkg::PMW1+1)'(zs_s2[p]);
		assign sz  = (lvtcp_pkg::PMW1+1)'(zc_s2[p]) - (lvtcp_pkg::PMW1+1)'(xs_s2[p]);
		assign sy  = (lvtcp_pkg::PMW2+1)'(ycp_s4[p]) + (lvtcp_pkg::PMW2+1)'(zsp_s4[p]);
		assign sz2 = (lvtcp_pkg::PMW2+1)'(zcp_s4[p]) - (lvtcp_pkg::PMW2+1)'(ysp_s4[p]);

		always_ff @(posedge clk) begin
			if (en) begin
				vx_s1[p] <= {ix[lvtcp_pkg::CW-1], ix}
					- {cfg.camera_x[lvtcp_pkg::CW-1], cfg.camera_x};
				vy_s1[p] <= {iy[lvtcp_pkg::CW-1], iy}
					- {cfg.camera_y[lvtcp_pkg::CW-1], cfg.camera_y};
				vz_s1[p] <= {iz[lvtcp_pkg::CW-1], iz}
					- {cfg.camera_z[lvtcp_pkg::CW-1], cfg.camera_z};

				xc_s2[p] <= vx_s1[p] * cfg.yaw_cosine;
				zs_s2[p] <= vz_s1[p] * cfg.yaw_sine;
				zc_s2[p] <= vz_s1[p] * cfg.yaw_cosine;
				xs_s2[p] <= vx_s1[p] * cfg.yaw_sine;
				vy_s2[p] <= vy_s1[p];

				x_s3[p]  <= lvtcp_pkg::VW'(sx >>> lvtcp_pkg::FRAC);
				z1_s3[p] <= lvtcp_pkg::ZW'(sz >>> lvtcp_pkg::FRAC);
				vy_s3[p] <= vy_s2[p];

				ycp_s4[p] <= vy_s3[p] * cfg.pitch_cosine;
				zsp_s4[p] <= z1_s3[p] * cfg.pitch_sine;
				zcp_s4[p] <= z1_s3[p] * cfg.pitch_cosine;
				ysp_s4[p] <= vy_s3[p] * cfg.pitch_sine;
				x_s4[p]   <= x_s3[p];
			end
		end

		assign pt[p].x = x_s4[p];
		assign pt[p].y = lvtcp_pkg::VW'(sy >>> lvtcp_pkg::FRAC);
		assign pt[p].z = lvtcp_pkg::VW'(sz2 >>> lvtcp_pkg::FRAC);
		assign near[p] = pt[p].z < lvtcp_pkg::NEAR_V;
	end

	always_comb begin
		push_item.a       = pt[0];
		push_item.b       = pt[1];
		push_item.a_near  = near[0];
		push_item.b_near  = near[1];
		push_item.visible = !(near[0] && near[1]);
	end

endmodule

// File: rtl/lvtcp_fifo.sv
module lvtcp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lvtcp_pkg::item_t din,
	output logic             full,
	input  logic             pop,
	output lvtcp_pkg::item_t dout,
	output logic             empty
);

	lvtcp_pkg::item_t                  mem [lvtcp_pkg::FIFO_DEPTH];
	logic [lvtcp_pkg::FIFO_AW-1:0]     wptr_q, rptr_q;
	logic [lvtcp_pkg::FIFO_AW:0]       cnt_q;

	assign full  = cnt_q == (lvtcp_pkg::FIFO_AW+1)'(lvtcp_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/lvtcp_clip_div.sv
module lvtcp_clip_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lvtcp_pkg::CDW-1:0]   num,
	input  logic [lvtcp_pkg::CDW-1:0]   den,
	input  logic [lvtcp_pkg::CDW-1:0]   mag_x,
	input  logic [lvtcp_pkg::CDW-1:0]   mag_y,
	output logic [lvtcp_pkg::CDW-1:0]   q_x,
	output logic [lvtcp_pkg::CDW-1:0]   q_y
);

	localparam int N = lvtcp_pkg::CDW;
	localparam int R = lvtcp_pkg::CRW;

	logic [N-1:0] num_s [N];
	logic [N-1:0] den_s [N];
	logic [N-1:0] mx_s  [N];
	logic [N-1:0] my_s  [N];
	logic [R-1:0] rx_s  [N];
	logic [R-1:0] ry_s  [N];
	logic [N-1:0] qx_s  [N];
	logic [N-1:0] qy_s  [N];

	// one bit of the multiplier per stage, remainder kept below den
	function automatic logic [R+1:0] step(input logic [R-1:0] r, input logic [N-1:0] n,
		input logic [N-1:0] d, input logic b);
		logic [R-1:0] t, d1, d2;
		begin
			t  = {r[R-2:0], 1'b0} + (b ? R'(n) : '0);
			d1 = R'(d);
			d2 = {d1[R-2:0], 1'b0};
			if (t >= d2) begin
				step = {t - d2, 2'd2};
			end else if (t >= d1) begin
				step = {t - d1, 2'd1};
			end else begin
				step = {t, 2'd0};
			end
		end
	endfunction

	for (genvar j = 0; j < N; j++) begin : g_st
		logic [N-1:0] pn, pd, pmx, pmy, pqx, pqy;
		logic [R-1:0] prx, pry;
		logic [R+1:0] sx, sy;

		if (j == 0) begin : g_first
			assign pn  = num;
			assign pd  = den;
			assign pmx = mag_x;
			assign pmy = mag_y;
			assign prx = '0;
			assign pry = '0;
			assign pqx = '0;
			assign pqy = '0;
		end else begin : g_next
			assign pn  = num_s[j-1];
			assign pd  = den_s[j-1];
			assign pmx = mx_s[j-1];
			assign pmy = my_s[j-1];
			assign prx = rx_s[j-1];
			assign pry = ry_s[j-1];
			assign pqx = qx_s[j-1];
			assign pqy = qy_s[j-1];
		end

		assign sx = step(prx, pn, pd, pmx[N-1-j]);
		assign sy = step(pry, pn, pd, pmy[N-1-j]);

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[j] <= pn;
				den_s[j] <= pd;
				mx_s[j]  <= pmx;
				my_s[j]  <= pmy;
				rx_s[j]  <= sx[R+1:2];
				ry_s[j]  <= sy[R+1:2];
				qx_s[j]  <= {pqx[N-2:0], 1'b0} + N'(sx[1:0]);
				qy_s[j]  <= {pqy[N-2:0], 1'b0} + N'(sy[1:0]);
			end
		end
	end

	assign q_x = qx_s[N-1];
	assign q_y = qy_s[N-1];

endmodule

// File: rtl/lvtcp_proj_div.sv
module lvtcp_proj_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [lvtcp_pkg::NW-1:0]   num,
	input  logic [lvtcp_pkg::PDW-1:0]         den,
	output logic signed [lvtcp_pkg::OW-1:0]   res
);

	localparam int N = lvtcp_pkg::NW;
	localparam int Q = lvtcp_pkg::QW;

	logic [N-1:0]                 r_s   [Q+1];
	logic [lvtcp_pkg::PDW-1:0]    d_s   [Q+1];
	logic [Q-1:0]                 q_s   [Q+1];
	logic                         ovf_s [Q+1];
	logic                         neg_s [Q+1];

	logic [N-1:0] mag;

	assign mag = num[N-1] ? N'(-num) : N'(num);

	// quotient saturates once it reaches 2^QW
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= mag;
			d_s[0]   <= den;
			q_s[0]   <= '0;
			neg_s[0] <= num[N-1];
			ovf_s[0] <= mag >= (N'(den) << Q);
		end
	end

	for (genvar j = 1; j <= Q; j++) begin : g_st
		logic [N-1:0] dsh;
		logic         take;

		assign dsh  = N'(d_s[j-1]) << (Q - j);
		assign take = r_s[j-1] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]   <= take ? r_s[j-1] - dsh : r_s[j-1];
				d_s[j]   <= d_s[j-1];
				q_s[j]   <= q_s[j-1] | (take ? Q'(1) << (Q - j) : '0);
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
			end
		end
	end

	always_comb begin
		if (neg_s[Q]) begin
			res = ovf_s[Q] ? lvtcp_pkg::SAT_MIN : -$signed(lvtcp_pkg::OW'(q_s[Q]));
		end else begin
			res = ovf_s[Q] ? lvtcp_pkg::SAT_MAX : $signed(lvtcp_pkg::OW'(q_s[Q]));
		end
	end

endmodule

// File: rtl/lvtcp_back.sv
module lvtcp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  lvtcp_pkg::item_t              q_item,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lvtcp_pkg::OUT_W-1:0]   m_tdata,
	output logic [0:0]                    m_tuser
);

	localparam int L = 1 + lvtcp_pkg::CLAT + 2 + lvtcp_pkg::PLAT;
	localparam int C = lvtcp_pkg::CDW;

	logic         en;
	logic [L-1:0] vld_q;

	logic                     clip_a, clip_b;
	lvtcp_pkg::vpoint_t       p, o;
	logic signed [C-1:0]      dx, dy;
	logic [C-1:0]             num_c, den_c;

	logic [C-1:0]             num_s1, den_s1, mx_s1, my_s1;
	lvtcp_pkg::clip_meta_t    meta_s1;
	lvtcp_pkg::clip_meta_t    dl_q [lvtcp_pkg::CLAT];
	logic [C-1:0]             qx, qy;

	lvtcp_pkg::clip_meta_t    md;
	lvtcp_pkg::vpoint_t       pc;
	logic signed [lvtcp_pkg::PW-1:0] sqx, sqy;
	lvtcp_pkg::cpoint_t       cpt, fa, fb;
	lvtcp_pkg::cpoint_t       pa_s2, pb_s2;
	logic                     vis_s2, vis_s3;

	logic signed [lvtcp_pkg::PW:0]   sax, say, sbx, sby;
	logic signed [lvtcp_pkg::NW-1:0] nax_s3, nay_s3, nbx_s3, nby_s3;
	logic [lvtcp_pkg::PDW-1:0]       da_s3, db_s3;
	logic                            vd_q [lvtcp_pkg::PLAT];
	logic signed [lvtcp_pkg::OW-1:0] rax, ray, rbx, rby;

	assign en       = !vld_q[L-1] || m_tready;
	assign pop      = q_valid && en;
	assign m_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], q_valid};
		end
	end

	// near end is slid onto the plane
	always_comb begin
		clip_a = q_item.a_near && !q_item.b_near;
		clip_b = q_item.b_near && !q_item.a_near;
		p      = clip_a ? q_item.a : q_item.b;
		o      = clip_a ? q_item.b : q_item.a;
		dx     = C'(o.x) - C'(p.x);
		dy     = C'(o.y) - C'(p.y);
		if (clip_a || clip_b) begin
			num_c = C'(lvtcp_pkg::NEAR_V) - C'(p.z);
			den_c = C'(o.z) - C'(p.z);
		end else begin
			num_c = '0;
			den_c = C'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1          <= num_c;
			den_s1          <= den_c;
			mx_s1           <= dx[C-1] ? C'(-dx) : C'(dx);
			my_s1           <= dy[C-1] ? C'(-dy) : C'(dy);
			meta_s1.visible <= q_item.visible;
			meta_s1.clip_a  <= clip_a;
			meta_s1.clip_b  <= clip_b;
			meta_s1.neg_x   <= dx[C-1];
			meta_s1.neg_y   <= dy[C-1];
			meta_s1.a       <= q_item.a;
			meta_s1.b       <= q_item.b;
		end
	end

	lvtcp_clip_div u_clip_div (
		.clk   (clk),
		.en    (en),
		.num   (num_s1),
		.den   (den_s1),
		.mag_x (mx_s1),
		.mag_y (my_s1),
		.q_x   (qx),
		.q_y   (qy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= meta_s1;
			for (int k = 1; k < lvtcp_pkg::CLAT; k++) begin
				dl_q[k] <= dl_q[k-1];
			end
		end
	end

	always_comb begin
		md    = dl_q[lvtcp_pkg::CLAT-1];
		sqx   = md.neg_x ? -$signed(lvtcp_pkg::PW'(qx)) : $signed(lvtcp_pkg::PW'(qx));
		sqy   = md.neg_y ? -$signed(lvtcp_pkg::PW'(qy)) : $signed(lvtcp_pkg::PW'(qy));
		pc    = md.clip_a ? md.a : md.b;
		cpt.x = lvtcp_pkg::PW'(pc.x) + sqx;
		cpt.y = lvtcp_pkg::PW'(pc.y) + sqy;
		cpt.z = lvtcp_pkg::NEAR_V;
		fa.x  = lvtcp_pkg::PW'(md.a.x);
		fa.y  = lvtcp_pkg::PW'(md.a.y);
		fa.z  = md.a.z;
		fb.x  = lvtcp_pkg::PW'(md.b.x);
		fb.y  = lvtcp_pkg::PW'(md.b.y);
		fb.z  = md.b.z;
		if (md.clip_a) begin
			fa = cpt;
		end
		if (md.clip_b) begin
			fb = cpt;
		end
		if (fa.z < lvtcp_pkg::ZMIN_V) begin
			fa.z = lvtcp_pkg::ZMIN_V;
		end
		if (fb.z < lvtcp_pkg::ZMIN_V) begin
			fb.z = lvtcp_pkg::ZMIN_V;
		end
	end

	assign sax = (lvtcp_pkg::PW+1)'(pa_s2.x) + (lvtcp_pkg::PW+1)'(pa_s2.z);
	assign say = (lvtcp_pkg::PW+1)'(pa_s2.z) - (lvtcp_pkg::PW+1)'(pa_s2.y);
	assign sbx = (lvtcp_pkg::PW+1)'(pb_s2.x) + (lvtcp_pkg::PW+1)'(pb_s2.z);
	assign sby = (lvtcp_pkg::PW+1)'(pb_s2.z) - (lvtcp_pkg::PW+1)'(pb_s2.y);

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2  <= fa;
			pb_s2  <= fb;
			vis_s2 <= md.visible;
			nax_s3 <= sax * lvtcp_pkg::SW_V;
			nay_s3 <= say * lvtcp_pkg::SH_V;
			nbx_s3 <= sbx * lvtcp_pkg::SW_V;
			nby_s3 <= sby * lvtcp_pkg::SH_V;
			da_s3  <= {pa_s2.z, 1'b0};
			db_s3  <= {pb_s2.z, 1'b0};
			vis_s3 <= vis_s2;
			vd_q[0] <= vis_s3;
			for (int k = 1; k < lvtcp_pkg::PLAT; k++) begin
				vd_q[k] <= vd_q[k-1];
			end
		end
	end

	lvtcp_proj_div u_div_ax (.clk(clk), .en(en), .num(nax_s3), .den(da_s3), .res(rax));
	lvtcp_proj_div u_div_ay (.clk(clk), .en(en), .num(nay_s3), .den(da_s3), .res(ray));
	lvtcp_proj_div u_div_bx (.clk(clk), .en(en), .num(nbx_s3), .den(db_s3), .res(rbx));
	lvtcp_proj_div u_div_by (.clk(clk), .en(en), .num(nby_s3), .den(db_s3), .res(rby));

	assign m_tuser = vd_q[lvtcp_pkg::PLAT-1];
	assign m_tdata = vd_q[lvtcp_pkg::PLAT-1] ? {rby, rbx, ray, rax} : '0;

endmodule

// File: rtl/line_view_transform_clip_project_unit.sv
// Line segment view transform, near-plane clip and perspective projection.
// Input stream s_*: one segment per transfer, two world-space endpoints in
// signed Q23.8. Output stream m_*: one result per segment, tuser set when the
// segment survives clipping, tdata holding the four pixel coordinates
// (all zero for a culled segment).
// Camera position and yaw/pitch sine and cosine must be written over the
// configuration port only while no segment is in flight; the block does
// not enforce this. One segment is taken every cycle while s_tready is
// high. The front has camera subtract, yaw multiply, yaw sum and pitch
// multiply registers; then comes the queue, then the back: clip set-up
// register, a 41-stage clip divider (one multiplier bit per stage), clip
// update and projection multiply registers and a 16-stage saturating divider.
// A four-entry queue sits between front and back. When the receiver holds
// off m_tready the back pipeline freezes, the queue fills and then s_tready
// falls; nothing is lost.
// Reset empties all pipelines and the queue and returns the registers to
// camera at the origin, yaw and pitch zero.
module line_view_transform_clip_project_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z
	input  logic [lvtcp_pkg::IN_W-1:0]    s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// start_x, start_y, end_x, end_y
	output logic [lvtcp_pkg::OUT_W-1:0]   m_tdata,
	// line_visible
	output logic [0:0]                    m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lvtcp_pkg::AW-1:0]      paddr,
	input  logic [lvtcp_pkg::DW-1:0]      pwdata,
	output logic [lvtcp_pkg::DW-1:0]      prdata,
	output logic                          pready
);

	lvtcp_pkg::cfg_t  cfg_q;
	logic             wr;
	logic [2:0]       idx;
	logic             push, full, pop, empty;
	lvtcp_pkg::item_t push_item, head;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[lvtcp_pkg::AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_x     <= '0;
			cfg_q.camera_y     <= '0;
			cfg_q.camera_z     <= '0;
			cfg_q.yaw_cosine   <= 16'sd16384;
			cfg_q.yaw_sine     <= '0;
			cfg_q.pitch_cosine <= 16'sd16384;
			cfg_q.pitch_sine   <= '0;
		end else if (wr) begin
			case (idx)
				lvtcp_pkg::REG_CAMERA_X:     cfg_q.camera_x     <= pwdata;
				lvtcp_pkg::REG_CAMERA_Y:     cfg_q.camera_y     <= pwdata;
				lvtcp_pkg::REG_CAMERA_Z:     cfg_q.camera_z     <= pwdata;
				lvtcp_pkg::REG_YAW_COSINE:   cfg_q.yaw_cosine   <= pwdata[15:0];
				lvtcp_pkg::REG_YAW_SINE:     cfg_q.yaw_sine     <= pwdata[15:0];
				lvtcp_pkg::REG_PITCH_COSINE: cfg_q.pitch_cosine <= pwdata[15:0];
				lvtcp_pkg::REG_PITCH_SINE:   cfg_q.pitch_sine   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			lvtcp_pkg::REG_CAMERA_X:     prdata = cfg_q.camera_x;
			lvtcp_pkg::REG_CAMERA_Y:     prdata = cfg_q.camera_y;
			lvtcp_pkg::REG_CAMERA_Z:     prdata = cfg_q.camera_z;
			lvtcp_pkg::REG_YAW_COSINE:   prdata = {16'h0, cfg_q.yaw_cosine};
			lvtcp_pkg::REG_YAW_SINE:     prdata = {16'h0, cfg_q.yaw_sine};
			lvtcp_pkg::REG_PITCH_COSINE: prdata = {16'h0, cfg_q.pitch_cosine};
			lvtcp_pkg::REG_PITCH_SINE:   prdata = {16'h0, cfg_q.pitch_sine};
			default:                     prdata = '0;
		endcase
	end

	lvtcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	lvtcp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_item),
		.full   (full),
		.pop    (pop),
		.dout   (head),
		.empty  (empty)
	);

	lvtcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!empty),
		.q_item   (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
